@@ sv/dense_layer_tanh_train_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dense tanh layer
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DENSE_LAYER_TANH_TRAIN_DEFINES_SVH
`define DENSE_LAYER_TANH_TRAIN_DEFINES_SVH

// Same-cycle implication.
`define DLTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DLTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dltt_pkg.sv @@
// ----------------------------------------------------------------------------
// dltt_pkg
// Shared constants, cell control types and arithmetic helpers of the layer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dltt_pkg;

  localparam int MAX_INPUTS  = 64;
  localparam int MAX_OUTPUTS = 16;
  localparam int DATA_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_INPUTS);
  localparam int OUT_W       = $clog2(MAX_OUTPUTS);
  localparam int CNT_W       = $clog2(MAX_INPUTS + MAX_OUTPUTS + 2);
  localparam int ACC_W       = 32;
  localparam int CHAIN_W     = 2 * DATA_BITS + OUT_W + 1;
  localparam int NI_W        = 7;
  localparam int NO_W        = 5;
  localparam int LR_W        = 16;

  localparam logic signed [DATA_BITS-1:0] BIAS_RESET = 16'sd41;

  localparam logic [2:0] CMD_LOAD_W = 3'd0;
  localparam logic [2:0] CMD_LOAD_B = 3'd1;
  localparam logic [2:0] CMD_FWD    = 3'd2;
  localparam logic [2:0] CMD_OGRAD  = 3'd3;
  localparam logic [2:0] CMD_BWD    = 3'd4;
  localparam logic [2:0] CMD_UPD    = 3'd5;

  localparam logic [1:0] KIND_ACT   = 2'd0;
  localparam logic [1:0] KIND_IGRAD = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [1:0] CFG_IN_COUNT  = 2'd0;
  localparam logic [1:0] CFG_OUT_COUNT = 2'd1;
  localparam logic [1:0] CFG_LRATE     = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WLOAD,
    OP_BLOAD,
    OP_FSTART,
    OP_FACC,
    OP_TANH,
    OP_DERIV,
    OP_GSCALE,
    OP_GACC,
    OP_BWG,
    OP_UB_MUL,
    OP_UB_SUB,
    OP_CLR
  } cell_op_e;

  typedef struct packed {
    cell_op_e                     op;
    logic [OUT_W-1:0]             sel;
    logic [IDX_W-1:0]             raddr;
    logic [IDX_W-1:0]             waddr;
    logic                         upd_go;
    logic signed [DATA_BITS-1:0]  value;
    logic [LR_W-1:0]              lr;
    logic [NI_W-1:0]              ni;
    logic [NO_W-1:0]              no;
  } cell_ctl_t;

  function automatic logic [12:0] tanh_lut(input logic [4:0] k);
    logic [12:0] t;
    case (k)
      5'd0:    t = 13'd0;
      5'd1:    t = 13'd1003;
      5'd2:    t = 13'd1893;
      5'd3:    t = 13'd2602;
      5'd4:    t = 13'd3119;
      5'd5:    t = 13'd3475;
      5'd6:    t = 13'd3707;
      5'd7:    t = 13'd3856;
      5'd8:    t = 13'd3949;
      5'd9:    t = 13'd4006;
      5'd10:   t = 13'd4041;
      5'd11:   t = 13'd4063;
      5'd12:   t = 13'd4076;
      5'd13:   t = 13'd4084;
      5'd14:   t = 13'd4089;
      5'd15:   t = 13'd4091;
      default: t = 13'd4096;
    endcase
    return t;
  endfunction

  function automatic logic signed [DATA_BITS-1:0] sat_data(input logic signed [39:0] v);
    logic signed [DATA_BITS-1:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[DATA_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [39:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/dltt_ram.sv @@
// ----------------------------------------------------------------------------
// dltt_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dltt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/dltt_cell.sv @@
// ----------------------------------------------------------------------------
// dltt_cell
// One neuron: weights, weight gradients, sum, bias and local gradient, plus
// one stage of the input gradient chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dltt_cell (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  dltt_pkg::cell_ctl_t                        ctl_i,
  input  logic [dltt_pkg::OUT_W-1:0]                 cell_idx_i,
  input  logic signed [dltt_pkg::CHAIN_W-1:0]        part_i,
  output logic signed [dltt_pkg::CHAIN_W-1:0]        part_o,
  output logic signed [dltt_pkg::DATA_BITS-1:0]      act_o
);

  logic                                   active;
  logic                                   sel_hit;
  logic signed [dltt_pkg::DATA_BITS-1:0]  value;
  logic signed [dltt_pkg::DATA_BITS-1:0]  bias_q, bias_d;
  logic signed [dltt_pkg::ACC_W-1:0]      sum_q, sum_d;
  logic signed [dltt_pkg::DATA_BITS-1:0]  lg_q, lg_d;
  logic signed [dltt_pkg::ACC_W-1:0]      bg_q, bg_d;
  logic signed [dltt_pkg::DATA_BITS-1:0]  y_q, y_d;
  logic signed [dltt_pkg::CHAIN_W-1:0]    part_q, part_d;
  logic signed [48:0]                     bprod_q, bprod_d;
  logic signed [48:0]                     wprod_q;
  logic signed [dltt_pkg::DATA_BITS-1:0]  w2_q;
  logic [dltt_pkg::IDX_W-1:0]             a1_q, a2_q;
  logic                                   v1_q, v2_q;

  logic [dltt_pkg::DATA_BITS-1:0]         w_rd_raw, w_wdata;
  logic [dltt_pkg::ACC_W-1:0]             wg_rd_raw, wg_wdata;
  logic signed [dltt_pkg::DATA_BITS-1:0]  w_rd;
  logic signed [dltt_pkg::ACC_W-1:0]      wg_rd;
  logic                                   w_we, wg_we;
  logic [dltt_pkg::IDX_W-1:0]             w_waddr, wg_waddr;

  logic signed [31:0]                     fprod, gprod, yy, bprod_c;
  logic signed [32:0]                     fround, ground;
  logic signed [32:0]                     sx;
  logic [32:0]                            mag;
  logic [12:0]                            t0, t1, tdiff, ymag;
  logic [22:0]                            df;
  logic signed [31:0]                     lg_new;
  logic signed [48:0]                     wprod_c;
  logic signed [32:0]                     wdelta, bdelta;
  logic signed [dltt_pkg::CHAIN_W-1:0]    term;

  assign active  = {1'b0, cell_idx_i} < ctl_i.no;
  assign sel_hit = ctl_i.sel == cell_idx_i;
  assign value   = $signed(ctl_i.value);
  assign w_rd    = $signed(w_rd_raw);
  assign wg_rd   = $signed(wg_rd_raw);

  assign fprod  = w_rd * value;
  assign fround = (33'(fprod) + 33'sd2048) >>> 12;
  assign gprod  = lg_q * value;
  assign ground = (33'(gprod) + 33'sd2048) >>> 12;

  assign sx    = 33'(sum_q);
  assign mag   = sx[32] ? 33'(-sx) : 33'(sx);
  assign t0    = dltt_pkg::tanh_lut({1'b0, mag[13:10]});
  assign t1    = dltt_pkg::tanh_lut({1'b0, mag[13:10]} + 5'd1);
  assign tdiff = t1 - t0;
  assign df    = 23'(tdiff) * 23'(mag[9:0]);
  assign ymag  = (|mag[32:14]) ? 13'd4096 : t0 + 13'((df + 23'd512) >> 10);
  assign y_d   = sum_q[31] ? -$signed({3'b000, ymag}) : $signed({3'b000, ymag});

  assign yy     = y_q * y_q;
  assign lg_new = 32'sd4096 - ((yy + 32'sd2048) >>> 12);

  assign term   = active ? dltt_pkg::CHAIN_W'(w_rd * lg_q) : '0;
  assign part_d = part_i + term;

  assign wprod_c = $signed({1'b0, ctl_i.lr}) * wg_rd;
  assign bprod_c = '0;
  assign bprod_d = $signed({1'b0, ctl_i.lr}) * bg_q;
  assign wdelta  = 33'((wprod_q + 49'sd32768) >>> 16);
  assign bdelta  = 33'((bprod_q + 49'sd32768) >>> 16);

  always_comb begin
    bias_d = bias_q;
    sum_d  = sum_q;
    lg_d   = lg_q;
    bg_d   = bg_q;
    case (ctl_i.op)
      dltt_pkg::OP_BLOAD: begin
        if (sel_hit) begin
          bias_d = value;
        end
      end
      dltt_pkg::OP_FSTART: begin
        sum_d = 32'(bias_q);
        lg_d  = '0;
        bg_d  = '0;
      end
      dltt_pkg::OP_FACC: begin
        if (active) begin
          sum_d = dltt_pkg::sat_acc(40'(sum_q) + 40'(fround) + 40'(bprod_c));
        end
      end
      dltt_pkg::OP_DERIV: begin
        if (active) begin
          lg_d = lg_new[dltt_pkg::DATA_BITS-1:0];
        end
      end
      dltt_pkg::OP_GSCALE: begin
        if (sel_hit) begin
          lg_d = dltt_pkg::sat_data(40'(ground));
        end
      end
      dltt_pkg::OP_GACC: begin
        if (sel_hit) begin
          bg_d = dltt_pkg::sat_acc(40'(bg_q) + 40'(lg_q));
        end
      end
      dltt_pkg::OP_UB_SUB: begin
        if (active) begin
          bias_d = dltt_pkg::sat_data(40'(bias_q) - 40'(bdelta));
        end
        bg_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    w_we    = 1'b0;
    w_waddr = ctl_i.waddr;
    w_wdata = ctl_i.value;
    if (v2_q) begin
      w_we    = active && (7'(a2_q) < ctl_i.ni);
      w_waddr = a2_q;
      w_wdata = dltt_pkg::sat_data(40'(w2_q) - 40'(wdelta));
    end else if (ctl_i.op == dltt_pkg::OP_WLOAD && sel_hit) begin
      w_we = 1'b1;
    end
  end

  always_comb begin
    wg_we    = 1'b0;
    wg_waddr = ctl_i.waddr;
    wg_wdata = '0;
    if (v2_q) begin
      wg_we    = 1'b1;
      wg_waddr = a2_q;
    end else if (ctl_i.op == dltt_pkg::OP_CLR) begin
      wg_we = 1'b1;
    end else if (ctl_i.op == dltt_pkg::OP_BWG) begin
      wg_we    = active;
      wg_waddr = ctl_i.raddr;
      wg_wdata = dltt_pkg::sat_acc(40'(wg_rd) + 40'(ground));
    end
  end

  dltt_ram #(
    .WIDTH (dltt_pkg::DATA_BITS),
    .DEPTH (dltt_pkg::MAX_INPUTS)
  ) u_w_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (ctl_i.raddr),
    .rdata_o (w_rd_raw)
  );

  dltt_ram #(
    .WIDTH (dltt_pkg::ACC_W),
    .DEPTH (dltt_pkg::MAX_INPUTS)
  ) u_wg_ram (
    .clk_i   (clk_i),
    .we_i    (wg_we),
    .waddr_i (wg_waddr),
    .wdata_i (wg_wdata),
    .raddr_i (ctl_i.raddr),
    .rdata_o (wg_rd_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= dltt_pkg::BIAS_RESET;
      sum_q  <= '0;
      lg_q   <= '0;
      bg_q   <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      bias_q <= bias_d;
      sum_q  <= sum_d;
      lg_q   <= lg_d;
      bg_q   <= bg_d;
      v1_q   <= ctl_i.upd_go;
      v2_q   <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    a1_q   <= ctl_i.raddr;
    a2_q   <= a1_q;
    w2_q   <= w_rd;
    wprod_q <= wprod_c;
    if (ctl_i.op == dltt_pkg::OP_TANH) begin
      y_q <= y_d;
    end
    if (ctl_i.op == dltt_pkg::OP_UB_MUL) begin
      bprod_q <= bprod_d;
    end
  end

  assign part_o = part_q;
  assign act_o  = y_q;

endmodule

@@ sv/dense_layer_tanh_train.sv @@
// ----------------------------------------------------------------------------
// dense_layer_tanh_train
// Fully connected tanh layer with gradient descent training in Q4.12.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   command, in_index, out_index, value
// out       output     out_valid_o/out_ready_i kind, index, result_value, last
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index, cfg_data
//
// A load is taken in the idle state; an output gradient adds state GACC.
// A forward element passes FRD and FACC; the last also TANH and DERIV, then
// emits each activation in turn. The first forward element adds a sweep
// that clears the weight gradients. A backward element passes BRD and BACC,
// set by the input gradient chain of 16 cells. An update steps one weight
// row entry per cycle in all cells at once. After reset a clearing sweep
// runs before the first item is taken. A result waits in one output
// register; while it is held, the next result and inputs behind it wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dense_layer_tanh_train_defines.svh"

module dense_layer_tanh_train (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [2:0]                             command_i,
  input  logic [5:0]                             in_index_i,
  input  logic [3:0]                             out_index_i,
  input  logic signed [15:0]                     value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [1:0]                             kind_o,
  output logic [5:0]                             index_o,
  output logic signed [15:0]                     result_value_o,
  output logic                                   last_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [1:0]                             cfg_index_i,
  input  logic [15:0]                            cfg_data_i
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FRD   = 4'd2;
  localparam logic [3:0] S_FACC  = 4'd3;
  localparam logic [3:0] S_TANH  = 4'd4;
  localparam logic [3:0] S_DERIV = 4'd5;
  localparam logic [3:0] S_GACC  = 4'd6;
  localparam logic [3:0] S_BRD   = 4'd7;
  localparam logic [3:0] S_BACC  = 4'd8;
  localparam logic [3:0] S_UPD   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]                          state_q, state_d;
  logic [dltt_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [dltt_pkg::OUT_W-1:0]          k_q, k_d;
  logic [dltt_pkg::IDX_W-1:0]          j_q, j_d;
  logic [dltt_pkg::OUT_W-1:0]          o_q, o_d;
  logic signed [15:0]                  v_q, v_d;
  logic [1:0]                          kind_q, kind_d;
  logic                                clr_fwd_q, clr_fwd_d;
  logic [dltt_pkg::NI_W-1:0]           in_count_q;
  logic [dltt_pkg::NO_W-1:0]           out_count_q;
  logic [dltt_pkg::LR_W-1:0]           lr_q;
  logic [dltt_pkg::NI_W-1:0]           ni;
  logic [dltt_pkg::NO_W-1:0]           no;

  logic                                out_valid_q;
  logic [1:0]                          out_kind_q, out_kind_d;
  logic [5:0]                          out_idx_q, out_idx_d;
  logic signed [15:0]                  out_val_q, out_val_d;
  logic                                out_last_q, out_last_d;
  logic                                out_load;

  dltt_pkg::cell_ctl_t                 ctl;
  logic signed [dltt_pkg::CHAIN_W-1:0] part [dltt_pkg::MAX_OUTPUTS+1];
  logic signed [15:0]                  act [dltt_pkg::MAX_OUTPUTS];
  logic signed [dltt_pkg::CHAIN_W-1:0] igrad_round;
  logic                                in_fire;

  assign ni = (in_count_q == '0) ? 7'd1 :
              ((in_count_q > 7'(dltt_pkg::MAX_INPUTS)) ? 7'(dltt_pkg::MAX_INPUTS) : in_count_q);
  assign no = (out_count_q == '0) ? 5'd1 :
              ((out_count_q > 5'(dltt_pkg::MAX_OUTPUTS)) ? 5'(dltt_pkg::MAX_OUTPUTS)
                                                         : out_count_q);

  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign igrad_round = (part[dltt_pkg::MAX_OUTPUTS] + dltt_pkg::CHAIN_W'(2048)) >>> 12;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    j_d        = j_q;
    o_d        = o_q;
    v_d        = v_q;
    kind_d     = kind_q;
    clr_fwd_d  = clr_fwd_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    out_kind_d = kind_q;
    out_idx_d  = '0;
    out_val_d  = '0;
    out_last_d = 1'b1;
    ctl        = '0;
    ctl.op     = dltt_pkg::OP_NONE;
    ctl.raddr  = j_q;
    ctl.waddr  = cnt_q[dltt_pkg::IDX_W-1:0];
    ctl.sel    = o_q;
    ctl.value  = v_q;
    ctl.lr     = lr_q;
    ctl.ni     = ni;
    ctl.no     = no;
    ctl.upd_go = 1'b0;
    case (state_q)
      S_CLR: begin
        ctl.op = dltt_pkg::OP_CLR;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == dltt_pkg::CNT_W'(dltt_pkg::MAX_INPUTS - 1)) begin
          cnt_d     = '0;
          clr_fwd_d = 1'b0;
          state_d   = clr_fwd_q ? S_FRD : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          j_d = in_index_i;
          o_d = out_index_i;
          v_d = value_i;
          case (command_i)
            dltt_pkg::CMD_LOAD_W: begin
              ctl.op    = dltt_pkg::OP_WLOAD;
              ctl.waddr = in_index_i;
              ctl.sel   = out_index_i;
              ctl.value = value_i;
            end
            dltt_pkg::CMD_LOAD_B: begin
              ctl.op    = dltt_pkg::OP_BLOAD;
              ctl.sel   = out_index_i;
              ctl.value = value_i;
            end
            dltt_pkg::CMD_FWD: begin
              if (7'(in_index_i) < ni) begin
                if (in_index_i == '0) begin
                  ctl.op    = dltt_pkg::OP_FSTART;
                  clr_fwd_d = 1'b1;
                  cnt_d     = '0;
                  state_d   = S_CLR;
                end else begin
                  state_d = S_FRD;
                end
              end
            end
            dltt_pkg::CMD_OGRAD: begin
              if (5'(out_index_i) < no) begin
                ctl.op    = dltt_pkg::OP_GSCALE;
                ctl.sel   = out_index_i;
                ctl.value = value_i;
                state_d   = S_GACC;
              end
            end
            dltt_pkg::CMD_BWD: begin
              if (7'(in_index_i) < ni) begin
                state_d = S_BRD;
              end
            end
            dltt_pkg::CMD_UPD: begin
              cnt_d   = '0;
              state_d = S_UPD;
            end
            default: begin
            end
          endcase
        end
      end
      S_FRD: begin
        state_d = S_FACC;
      end
      S_FACC: begin
        ctl.op  = dltt_pkg::OP_FACC;
        state_d = (7'(j_q) == ni - 7'd1) ? S_TANH : S_IDLE;
      end
      S_TANH: begin
        ctl.op  = dltt_pkg::OP_TANH;
        state_d = S_DERIV;
      end
      S_DERIV: begin
        ctl.op  = dltt_pkg::OP_DERIV;
        k_d     = '0;
        kind_d  = dltt_pkg::KIND_ACT;
        state_d = S_EMIT;
      end
      S_GACC: begin
        ctl.op  = dltt_pkg::OP_GACC;
        state_d = S_IDLE;
      end
      S_BRD: begin
        cnt_d   = '0;
        state_d = S_BACC;
      end
      S_BACC: begin
        if (cnt_q == '0) begin
          ctl.op = dltt_pkg::OP_BWG;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == dltt_pkg::CNT_W'(dltt_pkg::MAX_OUTPUTS - 1)) begin
          kind_d  = dltt_pkg::KIND_IGRAD;
          state_d = S_EMIT;
        end
      end
      S_UPD: begin
        ctl.raddr  = cnt_q[dltt_pkg::IDX_W-1:0];
        ctl.upd_go = cnt_q < dltt_pkg::CNT_W'(dltt_pkg::MAX_INPUTS);
        if (cnt_q == '0) begin
          ctl.op = dltt_pkg::OP_UB_MUL;
        end else if (cnt_q == dltt_pkg::CNT_W'(1)) begin
          ctl.op = dltt_pkg::OP_UB_SUB;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == dltt_pkg::CNT_W'(dltt_pkg::MAX_INPUTS + 1)) begin
          kind_d  = dltt_pkg::KIND_DONE;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          case (kind_q)
            dltt_pkg::KIND_ACT: begin
              out_idx_d  = 6'(k_q);
              out_val_d  = act[k_q];
              out_last_d = 5'(k_q) == no - 5'd1;
              k_d        = k_q + 1'b1;
              if (5'(k_q) == no - 5'd1) begin
                state_d = S_IDLE;
              end
            end
            dltt_pkg::KIND_IGRAD: begin
              out_idx_d  = j_q;
              out_val_d  = dltt_pkg::sat_data(40'(igrad_round));
              out_last_d = 7'(j_q) == ni - 7'd1;
              state_d    = S_IDLE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign part[0] = '0;

  for (genvar i = 0; i < dltt_pkg::MAX_OUTPUTS; i++) begin : g_cell
    dltt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .cell_idx_i (dltt_pkg::OUT_W'(i)),
      .part_i     (part[i]),
      .part_o     (part[i+1]),
      .act_o      (act[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      k_q         <= '0;
      kind_q      <= dltt_pkg::KIND_ACT;
      clr_fwd_q   <= 1'b0;
      in_count_q  <= 7'd64;
      out_count_q <= 5'd16;
      lr_q        <= 16'd655;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      kind_q    <= kind_d;
      clr_fwd_q <= clr_fwd_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          dltt_pkg::CFG_IN_COUNT:  in_count_q  <= cfg_data_i[dltt_pkg::NI_W-1:0];
          dltt_pkg::CFG_OUT_COUNT: out_count_q <= cfg_data_i[dltt_pkg::NO_W-1:0];
          dltt_pkg::CFG_LRATE:     lr_q        <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    o_q <= o_d;
    v_q <= v_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_idx_q  <= out_idx_d;
      out_val_q  <= out_val_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign index_o        = out_idx_q;
  assign result_value_o = out_val_q;
  assign last_o         = out_last_q;

  `DLTT_ASSERT_IMP(a_emit_in_range, (state_q == S_EMIT && kind_q == dltt_pkg::KIND_ACT), (5'(k_q) < no), "Activation index beyond neuron count.")
  `DLTT_ASSERT_NXT(a_fwd_start_clears, (in_fire && command_i == dltt_pkg::CMD_FWD && in_index_i == '0), (state_q == S_CLR), "First forward element did not start the clearing sweep.")
  `DLTT_ASSERT_NXT(a_upd_ends, (state_q == S_UPD && cnt_q == dltt_pkg::CNT_W'(dltt_pkg::MAX_INPUTS + 1)), (state_q == S_EMIT), "Update sweep did not end in its result.")
  `DLTT_ASSERT_IMP(a_no_load_when_full, (out_valid_q && !out_ready_i), (!out_load), "Result register overwritten while stalled.")

endmodule
